// ===== hw/rtl/msc_pkg.sv =====
package msc_pkg;

   localparam int SettleWidth = 16;
   localparam int DivWidth    = 11;
   localparam int IterWidth   = 4;
   localparam int ChanWidth   = 3;
   localparam int SumWidth    = 6;

   localparam logic [IterWidth-1:0] DivLastIter = IterWidth'(DivWidth - 1);
   localparam logic [ChanWidth-1:0] LastChan    = {ChanWidth{1'b1}};
   localparam logic [6:0]           OffsetScale = 7'd100;

   localparam logic [1:0] CsrActiveLevel = 2'd0;
   localparam logic [1:0] CsrMirrorOrder = 2'd1;
   localparam logic [1:0] CsrSettleUs    = 2'd2;

   typedef enum logic [1:0] {
      STEP_FETCH,
      STEP_DIV_LOAD,
      STEP_DIV_RUN,
      STEP_FINISH
   } step_type;

   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_SCAN_END,
      COND_ITER_END
   } cond_type;

   typedef struct packed {
      logic     accept_en;
      logic     div_load;
      logic     div_step;
      logic     finish;
      cond_type cond;
      step_type target;
   } ctl_word_type;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctl_type;

   function automatic ctl_word_type ucode(input step_type step);
      ctl_word_type w;
      begin
         w = '{accept_en: 1'b0, div_load: 1'b0, div_step: 1'b0, finish: 1'b0,
               cond: COND_ALWAYS, target: STEP_FETCH};
         unique case (step)
            STEP_FETCH: begin
               w.accept_en = 1'b1;
               w.cond      = COND_SCAN_END;
               w.target    = STEP_DIV_LOAD;
            end
            STEP_DIV_LOAD: begin
               w.div_load = 1'b1;
               w.cond     = COND_ALWAYS;
               w.target   = STEP_DIV_RUN;
            end
            STEP_DIV_RUN: begin
               w.div_step = 1'b1;
               w.cond     = COND_ITER_END;
               w.target   = STEP_FINISH;
            end
            STEP_FINISH: begin
               w.finish = 1'b1;
               w.cond   = COND_ALWAYS;
               w.target = STEP_FETCH;
            end
            default: w.target = STEP_FETCH;
         endcase
         return w;
      end
   endfunction

endpackage

// ===== hw/rtl/msc_div.sv =====
module msc_div (
   input  logic                          clock,
   input  msc_pkg::div_ctl_type          ctl,
   input  logic [msc_pkg::DivWidth-1:0]  dividend,
   input  logic [3:0]                    divisor,
   output logic [msc_pkg::DivWidth-1:0]  quotient
);

   logic [msc_pkg::DivWidth-1:0] quo_ff, quo_in;
   logic [3:0]                   rem_ff, rem_in;
   logic [4:0]                   trial;
   logic                         ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[msc_pkg::DivWidth-1]};
      ge     = (trial >= {1'b0, divisor});
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (ctl.load) begin
         quo_in = dividend;
         rem_in = 4'd0;
      end else if (ctl.step) begin
         quo_in = {quo_ff[msc_pkg::DivWidth-2:0], ge};
         rem_in = ge ? 4'(trial - {1'b0, divisor}) : trial[3:0];
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/mux_line_sensor_scan_centroid.sv =====
// Scanner for an eight-channel multiplexed line sensor with a weighted centroid.
// Each request on req_ is one microsecond tick carrying a start flag and the
// sensor pin level; every request yields exactly one response on rsp_ with the
// mux address to drive, the busy flag and the results of the last finished scan.
// rsp_tlast is high on the response of the tick that completes a scan.
// The csr_ port writes active level, mirror order and settle time; it is always
// ready and should only be written while no request is outstanding.
// An ordinary tick is accepted and its response is registered for the next cycle, so
// ticks may stream at one per cycle while rsp_tready stays high. The tick that completes
// a scan holds off new requests while the bit-serial divider forms the offset, one quotient bit per cycle.
// The response sits in an output register; a new request is taken while that
// register is empty or in the cycle its response leaves, so while a response
// waits with rsp_tready low no request is taken.
// Reset restores the register defaults, returns to idle with address 0 and
// clears the held results.
module mux_line_sensor_scan_centroid (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] start_req, [1] sense_level
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [2:0] mux_address, [3] busy_res, [11:4] raw_mask,
                                    // [15:12] hit_count, [26:16] offset_milli
   output logic        rsp_tlast,   // scan_done
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int SW = msc_pkg::SettleWidth;
   localparam int DW = msc_pkg::DivWidth;

   logic                  active_level_ff, active_level_in;
   logic                  mirror_order_ff, mirror_order_in;
   logic [SW-1:0]         settle_us_ff, settle_us_in;

   msc_pkg::step_type     step_ff, step_in;
   msc_pkg::ctl_word_type ctl;
   logic [msc_pkg::IterWidth-1:0] iter_ff, iter_in;

   logic                  scanning_ff, scanning_in;
   logic [2:0]            chan_ff, chan_in;
   logic [SW-1:0]         settle_left_ff, settle_left_in;
   logic [7:0]            mask_ff, mask_in;
   logic [3:0]            count_ff, count_in;
   logic signed [msc_pkg::SumWidth-1:0] sum_ff, sum_in;
   logic [7:0]            held_mask_ff, held_mask_in;
   logic [3:0]            held_count_ff, held_count_in;
   logic signed [DW-1:0]  held_offset_ff, held_offset_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  req_fire;
   logic                  start_req, sense_level;
   logic [SW-1:0]         settle_load, settle_dec;
   logic [2:0]            pos;
   logic signed [msc_pkg::SumWidth-1:0] weight;
   logic                  scan_end;
   logic                  taken;

   logic [4:0]            sum_abs;
   logic [DW-1:0]         scaled;
   logic [DW-1:0]         quotient;
   msc_pkg::div_ctl_type  div_ctl;

   assign csr_ready = 1'b1;

   always_comb begin
      active_level_in = active_level_ff;
      mirror_order_in = mirror_order_ff;
      settle_us_in    = settle_us_ff;
      if (csr_valid) begin
         unique case (csr_index)
            msc_pkg::CsrActiveLevel: active_level_in = csr_data[0];
            msc_pkg::CsrMirrorOrder: mirror_order_in = csr_data[0];
            msc_pkg::CsrSettleUs:    settle_us_in    = csr_data;
            default: ;
         endcase
      end
   end

   // Microcode fetch and step sequencing.
   always_comb begin
      ctl = msc_pkg::ucode(step_ff);
   end

   assign req_tready = ctl.accept_en && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign div_ctl    = '{load: ctl.div_load, step: ctl.div_step};

   always_comb begin
      unique case (ctl.cond)
         msc_pkg::COND_ALWAYS:   taken = 1'b1;
         msc_pkg::COND_SCAN_END: taken = req_fire && scan_end;
         msc_pkg::COND_ITER_END: taken = (iter_ff == '0);
         default:                taken = 1'b1;
      endcase
      step_in = taken ? ctl.target : step_ff;
      iter_in = iter_ff;
      if (ctl.div_load) begin
         iter_in = msc_pkg::DivLastIter;
      end else if (ctl.div_step && iter_ff != '0) begin
         iter_in = iter_ff - 1'b1;
      end
   end

   // One tick of the scan.
   assign start_req   = req_tdata[0];
   assign sense_level = req_tdata[1];
   assign settle_load = (settle_us_ff == '0) ? SW'(1) : settle_us_ff;
   assign settle_dec  = (settle_left_ff != '0) ? settle_left_ff - 1'b1 : settle_left_ff;
   assign pos         = mirror_order_ff ? ~chan_ff : chan_ff;
   assign weight      = $signed({2'b00, pos, 1'b0}) - 6'sd7;
   assign scan_end    = scanning_ff && (settle_dec == '0) && (chan_ff == msc_pkg::LastChan);

   always_comb begin
      scanning_in    = scanning_ff;
      chan_in        = chan_ff;
      settle_left_in = settle_left_ff;
      mask_in        = mask_ff;
      count_in       = count_ff;
      sum_in         = sum_ff;
      held_mask_in   = held_mask_ff;
      held_count_in  = held_count_ff;
      if (req_fire) begin
         if (!scanning_ff) begin
            if (start_req) begin
               scanning_in    = 1'b1;
               chan_in        = '0;
               settle_left_in = settle_load;
               mask_in        = '0;
               count_in       = '0;
               sum_in         = '0;
            end
         end else begin
            settle_left_in = settle_dec;
            if (settle_dec == '0) begin
               if (sense_level == active_level_ff) begin
                  mask_in  = mask_ff | (8'd1 << chan_ff);
                  count_in = count_ff + 1'b1;
                  sum_in   = sum_ff + weight;
               end
               if (chan_ff != msc_pkg::LastChan) begin
                  chan_in        = chan_ff + 1'b1;
                  settle_left_in = settle_load;
               end else begin
                  scanning_in   = 1'b0;
                  held_mask_in  = mask_in;
                  held_count_in = count_in;
               end
            end
         end
      end
   end

   // Offset: magnitude of the sum times one hundred, divided by the count.
   assign sum_abs = sum_ff[msc_pkg::SumWidth-1] ? 5'(-sum_ff) : sum_ff[4:0];
   assign scaled  = DW'(sum_abs) * DW'(msc_pkg::OffsetScale);

   msc_div u_div (
      .clock    (clock),
      .ctl      (div_ctl),
      .dividend (scaled),
      .divisor  (held_count_ff),
      .quotient (quotient)
   );

   always_comb begin
      held_offset_in = held_offset_ff;
      if (ctl.finish) begin
         if (held_count_ff == '0) begin
            held_offset_in = '0;
         end else if (sum_ff[msc_pkg::SumWidth-1]) begin
            held_offset_in = $signed(-quotient);
         end else begin
            held_offset_in = $signed(quotient);
         end
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (req_fire && !scan_end) begin
         rsp_data_in  = {5'd0, held_offset_ff, held_count_ff, held_mask_ff,
                         scanning_in, chan_in};
         rsp_last_in  = 1'b0;
         rsp_valid_in = 1'b1;
      end else if (ctl.finish) begin
         rsp_data_in  = {5'd0, held_offset_in, held_count_ff, held_mask_ff,
                         scanning_ff, chan_ff};
         rsp_last_in  = 1'b1;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff <= 1'b1;
         mirror_order_ff <= 1'b0;
         settle_us_ff    <= SW'(1);
         step_ff         <= msc_pkg::STEP_FETCH;
         iter_ff         <= '0;
         scanning_ff     <= 1'b0;
         chan_ff         <= '0;
         settle_left_ff  <= '0;
         mask_ff         <= '0;
         count_ff        <= '0;
         sum_ff          <= '0;
         held_mask_ff    <= '0;
         held_count_ff   <= '0;
         held_offset_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         active_level_ff <= active_level_in;
         mirror_order_ff <= mirror_order_in;
         settle_us_ff    <= settle_us_in;
         step_ff         <= step_in;
         iter_ff         <= iter_in;
         scanning_ff     <= scanning_in;
         chan_ff         <= chan_in;
         settle_left_ff  <= settle_left_in;
         mask_ff         <= mask_in;
         count_ff        <= count_in;
         sum_ff          <= sum_in;
         held_mask_ff    <= held_mask_in;
         held_count_ff   <= held_count_in;
         held_offset_ff  <= held_offset_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A completed scan leaves the block idle at the last address.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> !rsp_data_ff[3] && rsp_data_ff[2:0] == msc_pkg::LastChan)
      else $error("scan completion reported while busy or off the last address");

   // While scanning the settle counter never rests at zero.
   a_settle_live: assert property (@(posedge clock) disable iff (reset)
      scanning_ff |-> settle_left_ff != '0)
      else $error("settle counter at zero during a scan");

   // The divider loop stays within its quotient length.
   a_iter_range: assert property (@(posedge clock) disable iff (reset)
      step_ff == msc_pkg::STEP_DIV_RUN |-> iter_ff <= msc_pkg::DivLastIter)
      else $error("divider iteration count out of range");

   // The finishing step always presents a response.
   a_finish_rsp: assert property (@(posedge clock) disable iff (reset)
      step_ff == msc_pkg::STEP_FINISH |=> rsp_valid_ff && rsp_last_ff)
      else $error("finishing step produced no response");

endmodule
